// File: src/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg: shared types and constants of the threshold alert engine
// Word layouts, register indexes, input and result kinds, severity table.
// ----------------------------------------------------------------------------
package tae_pkg;

   // number of threshold rules
   localparam int RULE_COUNT = 3;
   localparam int RULE_IDX_W = $clog2(RULE_COUNT);

   // field widths
   localparam int VALUE_W   = 24;
   localparam int LEVEL_W   = 23;
   localparam int TIME_W    = 48;
   localparam int ID_W      = 32;
   localparam int DUR_W     = 16;
   localparam int TIMEOUT_W = 32;
   localparam int CMP_W     = LEVEL_W + 2;   // signed compare width

   // packed stream widths
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 144;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CELL_VOLTAGE_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PACK_DELTA_LIMIT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TEMPERATURE_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_VOLTAGE_BAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PACK_DELTA_BAND    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TEMPERATURE_BAND   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_QUAL_TIME_MS       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TIMEOUT_MS   = 3'd7;

   // register reset values
   localparam logic [LEVEL_W-1:0]   RST_CELL_VOLTAGE_LIMIT = 23'd58400;
   localparam logic [LEVEL_W-1:0]   RST_PACK_DELTA_LIMIT   = 23'd1920;
   localparam logic [LEVEL_W-1:0]   RST_TEMPERATURE_LIMIT  = 23'd960;
   localparam logic [LEVEL_W-1:0]   RST_CELL_VOLTAGE_BAND  = 23'd800;
   localparam logic [LEVEL_W-1:0]   RST_PACK_DELTA_BAND    = 23'd320;
   localparam logic [LEVEL_W-1:0]   RST_TEMPERATURE_BAND   = 23'd80;
   localparam logic [DUR_W-1:0]     RST_QUAL_TIME_MS       = 16'd500;
   localparam logic [TIMEOUT_W-1:0] RST_FRAME_TIMEOUT_MS   = 32'd5000;

   // input kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   // result kinds
   localparam logic [1:0] RES_COUNTERS = 2'd0;
   localparam logic [1:0] RES_RAISED   = 2'd1;
   localparam logic [1:0] RES_CLEARED  = 2'd2;

   // watchdog alarm codes
   localparam logic [1:0] SRC_WATCHDOG   = 2'd3;
   localparam logic [2:0] SEV_WDOG_RAISE = 3'd4;
   localparam logic [2:0] SEV_WDOG_CLEAR = 3'd1;

   typedef struct packed {
      logic [RULE_COUNT-1:0][LEVEL_W-1:0] limit;
      logic [RULE_COUNT-1:0][LEVEL_W-1:0] band;
      logic [DUR_W-1:0]                   qual_time_ms;
      logic [TIMEOUT_W-1:0]               frame_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic [1:0]                rule_index;
      logic signed [VALUE_W-1:0] sample_value;
      logic [TIME_W-1:0]         time_ms;
      logic [ID_W-1:0]           ack_id;
   } req_item_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic [ID_W-1:0]   alert_num;
      logic [2:0]        severity;
      logic [1:0]        alert_source;
      logic [TIME_W-1:0] alert_time_ms;
      logic              alert_acked;
      logic [2:0]        active_total;
      logic [1:0]        acked_total;
      logic              watchdog_active;
      logic [TIME_W-1:0] frame_time_ms;
      logic              last_of_run;
   } rsp_item_type;

   // results of one item: first word, optional second word, count
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } core_out_type;

   // severity of a rule alarm: rule 0 maps to 3, rule 1 to 2, any other rule to 4
   function automatic logic [2:0] rule_severity(input logic [RULE_IDX_W-1:0] rule);
      logic [2:0] sev;
      case (rule)
         2'd0:    sev = 3'd3;
         2'd1:    sev = 3'd2;
         default: sev = 3'd4;
      endcase
      return sev;
   endfunction

endpackage

// File: src/tae_csr_regs.sv
// ----------------------------------------------------------------------------
// tae_csr_regs: configuration registers
// Decodes register writes and holds thresholds, bands and timing limits.
// ----------------------------------------------------------------------------
module tae_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [tae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tae_pkg::CSR_DATA_W-1:0]   csr_data,
   output tae_pkg::cfg_type                 cfg
);

   tae_pkg::cfg_type cfg_ff, cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tae_pkg::REG_CELL_VOLTAGE_LIMIT:
               cfg_in.limit[0] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_PACK_DELTA_LIMIT:
               cfg_in.limit[1] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_TEMPERATURE_LIMIT:
               cfg_in.limit[2] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_CELL_VOLTAGE_BAND:
               cfg_in.band[0] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_PACK_DELTA_BAND:
               cfg_in.band[1] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_TEMPERATURE_BAND:
               cfg_in.band[2] = csr_data[tae_pkg::LEVEL_W-1:0];
            tae_pkg::REG_QUAL_TIME_MS:
               cfg_in.qual_time_ms = csr_data[tae_pkg::DUR_W-1:0];
            tae_pkg::REG_FRAME_TIMEOUT_MS:
               cfg_in.frame_timeout_ms = csr_data[tae_pkg::TIMEOUT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit[0]         <= tae_pkg::RST_CELL_VOLTAGE_LIMIT;
         cfg_ff.limit[1]         <= tae_pkg::RST_PACK_DELTA_LIMIT;
         cfg_ff.limit[2]         <= tae_pkg::RST_TEMPERATURE_LIMIT;
         cfg_ff.band[0]          <= tae_pkg::RST_CELL_VOLTAGE_BAND;
         cfg_ff.band[1]          <= tae_pkg::RST_PACK_DELTA_BAND;
         cfg_ff.band[2]          <= tae_pkg::RST_TEMPERATURE_BAND;
         cfg_ff.qual_time_ms     <= tae_pkg::RST_QUAL_TIME_MS;
         cfg_ff.frame_timeout_ms <= tae_pkg::RST_FRAME_TIMEOUT_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/tae_alarm_core.sv
// ----------------------------------------------------------------------------
// tae_alarm_core: alarm state and single-pass evaluation
// Holds rule, id, counter and watchdog state; builds the result words of
// the registered input word and commits the new state when it is taken.
// ----------------------------------------------------------------------------
module tae_alarm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  tae_pkg::req_item_type item,
   input  tae_pkg::cfg_type      cfg,
   output tae_pkg::core_out_type res
);

   localparam int RC = tae_pkg::RULE_COUNT;
   localparam int TW = tae_pkg::TIME_W;
   localparam int IW = tae_pkg::ID_W;
   localparam int CW = tae_pkg::CMP_W;

   // rule state
   logic [RC-1:0] active_ff, active_in;
   logic [RC-1:0] pending_ff, pending_in;
   logic [RC-1:0] acked_ff, acked_in;
   logic [TW-1:0] start_ff [RC];
   logic [TW-1:0] start_in [RC];
   logic [IW-1:0] id_ff [RC];
   logic [IW-1:0] id_in [RC];
   logic [TW-1:0] atime_ff [RC];
   logic [TW-1:0] atime_in [RC];

   // shared state
   logic [IW-1:0] next_id_ff, next_id_in;
   logic [2:0]    active_cnt_ff, active_cnt_in;
   logic [TW-1:0] last_frame_ff, last_frame_in;
   logic          comm_ff, comm_in;

   // rule select and compare
   logic [tae_pkg::RULE_IDX_W-1:0] rsel;
   logic                           rule_ok;
   logic signed [CW-1:0]           value_s, on_s, off_s;
   logic                           over_on, under_off;
   logic [TW-1:0]                  start_eff, elapsed, silence;
   logic                           qualified, timeout;

   assign rsel      = item.rule_index[tae_pkg::RULE_IDX_W-1:0];
   assign rule_ok   = item.rule_index < 2'(RC);
   assign value_s   = CW'($signed(item.sample_value));
   assign on_s      = $signed({2'b00, cfg.limit[rsel]});
   assign off_s     = on_s - $signed({2'b00, cfg.band[rsel]});
   assign over_on   = value_s >= on_s;
   assign under_off = value_s <= off_s;
   assign start_eff = pending_ff[rsel] ? start_ff[rsel] : item.time_ms;
   assign elapsed   = item.time_ms - start_eff;
   assign qualified = elapsed >= TW'(cfg.qual_time_ms);
   assign silence   = item.time_ms - last_frame_ff;
   assign timeout   = (last_frame_ff != '0) && (silence > TW'(cfg.frame_timeout_ms));

   // next state and result words
   always_comb begin
      logic                 found;
      logic                 has_alert;
      logic [1:0]           n_acked;
      tae_pkg::rsp_item_type alert;
      tae_pkg::rsp_item_type counters;

      active_in     = active_ff;
      pending_in    = pending_ff;
      acked_in      = acked_ff;
      start_in      = start_ff;
      id_in         = id_ff;
      atime_in      = atime_ff;
      next_id_in    = next_id_ff;
      active_cnt_in = active_cnt_ff;
      last_frame_in = last_frame_ff;
      comm_in       = comm_ff;
      found         = 1'b0;
      has_alert     = 1'b0;
      alert         = '0;
      counters      = '0;
      res.count     = 2'd0;

      unique case (item.kind)
         tae_pkg::KIND_SAMPLE: begin
            last_frame_in = item.time_ms;
            res.count     = 2'd1;
            if (rule_ok) begin
               if (over_on) begin
                  pending_in[rsel] = 1'b1;
                  if (!pending_ff[rsel])
                     start_in[rsel] = item.time_ms;
                  if (!active_ff[rsel] && qualified) begin
                     active_in[rsel] = 1'b1;
                     acked_in[rsel]  = 1'b0;
                     id_in[rsel]     = next_id_ff;
                     atime_in[rsel]  = item.time_ms;
                     next_id_in      = next_id_ff + 1'b1;
                     if (active_cnt_ff != 3'd7)
                        active_cnt_in = active_cnt_ff + 3'd1;
                     has_alert           = 1'b1;
                     alert.result_kind   = tae_pkg::RES_RAISED;
                     alert.alert_num     = next_id_ff;
                     alert.severity      = tae_pkg::rule_severity(rsel);
                     alert.alert_source  = item.rule_index;
                     alert.alert_time_ms = item.time_ms;
                  end
               end else if (under_off) begin
                  pending_in[rsel] = 1'b0;
                  if (active_ff[rsel]) begin
                     active_in[rsel] = 1'b0;
                     if (active_cnt_ff != 3'd0)
                        active_cnt_in = active_cnt_ff - 3'd1;
                     has_alert           = 1'b1;
                     alert.result_kind   = tae_pkg::RES_CLEARED;
                     alert.alert_num     = id_ff[rsel];
                     alert.severity      = tae_pkg::rule_severity(rsel);
                     alert.alert_source  = item.rule_index;
                     alert.alert_time_ms = atime_ff[rsel];
                     alert.alert_acked   = acked_ff[rsel];
                  end
               end
            end
            if (has_alert)
               res.count = 2'd2;
         end
         tae_pkg::KIND_FRAME: begin
            last_frame_in = item.time_ms;
            res.count     = 2'd1;
         end
         tae_pkg::KIND_ACK: begin
            // first active rule holding this id
            for (int i = 0; i < RC; i++) begin
               if (!found && active_ff[i] && id_ff[i] == item.ack_id) begin
                  found       = 1'b1;
                  acked_in[i] = 1'b1;
               end
            end
            res.count = found ? 2'd1 : 2'd0;
         end
         tae_pkg::KIND_TICK: begin
            if (timeout && !comm_ff) begin
               comm_in    = 1'b1;
               next_id_in = next_id_ff + 1'b1;
               if (active_cnt_ff != 3'd7)
                  active_cnt_in = active_cnt_ff + 3'd1;
               alert.result_kind   = tae_pkg::RES_RAISED;
               alert.alert_num     = next_id_ff;
               alert.severity      = tae_pkg::SEV_WDOG_RAISE;
               alert.alert_source  = tae_pkg::SRC_WATCHDOG;
               alert.alert_time_ms = item.time_ms;
               res.count           = 2'd2;
            end else if (!timeout && comm_ff) begin
               comm_in = 1'b0;
               if (active_cnt_ff != 3'd0)
                  active_cnt_in = active_cnt_ff - 3'd1;
               alert.result_kind   = tae_pkg::RES_CLEARED;
               alert.severity      = tae_pkg::SEV_WDOG_CLEAR;
               alert.alert_source  = tae_pkg::SRC_WATCHDOG;
               alert.alert_time_ms = item.time_ms;
               res.count           = 2'd2;
            end
         end
         default: res.count = 2'd0;
      endcase

      // acked rule alarms, saturating at three
      n_acked = 2'd0;
      for (int i = 0; i < RC; i++) begin
         if (active_in[i] && acked_in[i] && n_acked != 2'd3)
            n_acked = n_acked + 2'd1;
      end

      // counters word after the update
      counters.result_kind     = tae_pkg::RES_COUNTERS;
      counters.active_total    = active_cnt_in;
      counters.acked_total     = n_acked;
      counters.watchdog_active = comm_in;
      counters.frame_time_ms   = last_frame_in;
      counters.last_of_run     = 1'b1;

      if (res.count == 2'd2) begin
         res.first  = alert;
         res.second = counters;
      end else begin
         res.first  = counters;
         res.second = counters;
      end
   end

   // state commit
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         pending_ff    <= '0;
         acked_ff      <= '0;
         next_id_ff    <= IW'(1);
         active_cnt_ff <= 3'd0;
         last_frame_ff <= '0;
         comm_ff       <= 1'b0;
         for (int i = 0; i < RC; i++) begin
            start_ff[i] <= '0;
            id_ff[i]    <= '0;
            atime_ff[i] <= '0;
         end
      end else if (fire) begin
         active_ff     <= active_in;
         pending_ff    <= pending_in;
         acked_ff      <= acked_in;
         next_id_ff    <= next_id_in;
         active_cnt_ff <= active_cnt_in;
         last_frame_ff <= last_frame_in;
         comm_ff       <= comm_in;
         for (int i = 0; i < RC; i++) begin
            start_ff[i] <= start_in[i];
            id_ff[i]    <= id_in[i];
            atime_ff[i] <= atime_in[i];
         end
      end
   end

endmodule

// File: src/tae_result_buffer.sv
// ----------------------------------------------------------------------------
// tae_result_buffer: two-word result register
// Takes up to two result words of one input word and presents them in order.
// ----------------------------------------------------------------------------
module tae_result_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tae_pkg::core_out_type res,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output tae_pkg::rsp_item_type rsp_item,
   output logic                  can_load
);

   tae_pkg::rsp_item_type slot0_ff, slot1_ff;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  pop;

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_item   = slot0_ff;
   assign pop        = rsp_tvalid && rsp_tready;
   // empty after this cycle
   assign can_load   = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (load)
         cnt_in = res.count;
      else if (pop)
         cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         cnt_ff <= 2'd0;
      else
         cnt_ff <= cnt_in;
   end

   // word slots
   always_ff @(posedge clock) begin
      if (load) begin
         slot0_ff <= res.first;
         slot1_ff <= res.second;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

endmodule

// File: src/threshold_alert_engine.sv
// ----------------------------------------------------------------------------
// threshold_alert_engine: threshold alarms with hysteresis and watchdog
// Three rule alarms with qualification time plus a frame watchdog.
// ----------------------------------------------------------------------------
// Usage:
//  req_*  input words: tuser is the kind (sample, stats frame, acknowledge,
//         watchdog tick), tdata the rule, value, time and ack id.
//  rsp_*  result words: tuser is the result kind, tlast marks the last
//         word caused by one input word (the counters word).
//  csr_*  register writes, index and data; always ready. Write only while
//         the block is idle.
//  Path: an input word is registered in the input register, evaluated in
//  one pass once the result register can take it, and its result words are
//  loaded into the result register, which shows the first of them.
//  Throughput: one input word per cycle while rsp_tready is high and it
//  causes at most one result word; one that causes an alert and a counters
//  word holds the next until the single result channel has taken both.
//  Reset: registers return to their defaults, all alarms clear, next id is
//  one and the watchdog stays off until a frame or sample; no clearing pass.
//  Stall: results wait in a two-word register; one more input word is held
//  in the input register, then req_tready drops until rsp_tready returns.
// ----------------------------------------------------------------------------
module threshold_alert_engine (
   input  logic                             clock,
   input  logic                             reset,
   // req_tuser: kind[1:0]
   // req_tdata: rule_index[1:0], sample_value[25:2], time_ms[73:26],
   //            ack_id[105:74], zero[111:106]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tae_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                       req_tuser,
   // rsp_tuser: result_kind[1:0]
   // rsp_tdata: alert_num[31:0], severity[34:32], alert_source[36:35],
   //            alert_time_ms[84:37], alert_acked[85], active_total[88:86],
   //            acked_total[90:89], watchdog_active[91], frame_time_ms[139:92],
   //            zero[143:140]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tae_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tae_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tae_pkg::CSR_DATA_W-1:0]   csr_data
);

   tae_pkg::cfg_type      cfg;
   tae_pkg::req_item_type in_item_ff, in_item_in;
   tae_pkg::core_out_type core_res;
   tae_pkg::rsp_item_type rsp_item;
   logic                  in_valid_ff;
   logic                  can_load;
   logic                  fire;

   assign csr_ready = 1'b1;

   tae_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input word unpack
   assign in_item_in.kind         = req_tuser;
   assign in_item_in.rule_index   = req_tdata[1:0];
   assign in_item_in.sample_value = $signed(req_tdata[25:2]);
   assign in_item_in.time_ms      = req_tdata[73:26];
   assign in_item_in.ack_id       = req_tdata[105:74];

   // input register
   assign fire       = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else if (req_tready)
         in_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid)
         in_item_ff <= in_item_in;
   end

   tae_alarm_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .cfg   (cfg),
      .res   (core_res)
   );

   tae_result_buffer u_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res        (core_res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_item   (rsp_item),
      .can_load   (can_load)
   );

   // result word pack
   assign rsp_tuser = rsp_item.result_kind;
   assign rsp_tlast = rsp_item.last_of_run;
   assign rsp_tdata = {4'b0000,
                       rsp_item.frame_time_ms,
                       rsp_item.watchdog_active,
                       rsp_item.acked_total,
                       rsp_item.active_total,
                       rsp_item.alert_acked,
                       rsp_item.alert_time_ms,
                       rsp_item.alert_source,
                       rsp_item.severity,
                       rsp_item.alert_num};

endmodule

// File: src/tae_checker.sv
// ----------------------------------------------------------------------------
// tae_checker: port-level checks of the threshold alert engine
// Watches the result stream for ordering and counter consistency.
// ----------------------------------------------------------------------------
module tae_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tae_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                     rsp_tuser,
   input logic                           rsp_tlast
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // only the counters word closes a run
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == tae_pkg::RES_COUNTERS)))
      else $error("tlast does not match result kind");

   // an alert word is followed at once by its counters word
   a_alert_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("alert word not followed by counters word");

   // acked rule alarms never exceed active alarms, at most four active
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         ({1'b0, rsp_tdata[90:89]} <= rsp_tdata[88:86]) && (rsp_tdata[88:86] <= 3'd4))
      else $error("counter fields out of range");

endmodule

bind threshold_alert_engine tae_checker u_tae_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/threshold_alert_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_alert_engine_tb: self-checking regression of the alert engine
// Streams sample, stats frame, acknowledge and watchdog tick words into the
// engine under several register settings, keeps a cycle-free model of the
// alarm state and compares every alert and counters word field by field.
// ----------------------------------------------------------------------------
module threshold_alert_engine_tb;

   // rule alarm severities, lowest entry is rule 0
   localparam logic [2:0] SEV_CELL_VOLTAGE = 3'd3;
   localparam logic [2:0] SEV_PACK_DELTA   = 3'd2;
   localparam logic [2:0] SEV_TEMPERATURE  = 3'd4;
   localparam logic [tae_pkg::RULE_COUNT-1:0][2:0] SEV_RULE =
      {SEV_TEMPERATURE, SEV_PACK_DELTA, SEV_CELL_VOLTAGE};

   localparam logic [tae_pkg::LEVEL_W-1:0] LEVEL_MAX   = 23'h7F_FFFF;
   localparam int                          PHASE_WORDS = 261;

   typedef struct packed {
      tae_pkg::req_item_type word;
      logic                  hold;    // wait for all results before sending
   } pending_word_type;

   // DUT signals
   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tae_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                     req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tae_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [tae_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [tae_pkg::CSR_DATA_W-1:0] csr_data   = '0;

   // register copies
   logic [tae_pkg::LEVEL_W-1:0]   lim_set  [tae_pkg::RULE_COUNT];
   logic [tae_pkg::LEVEL_W-1:0]   band_set [tae_pkg::RULE_COUNT];
   logic [tae_pkg::DUR_W-1:0]     dur_set;
   logic [tae_pkg::TIMEOUT_W-1:0] wdog_set;

   // alarm state copy
   logic                       alarm_on    [tae_pkg::RULE_COUNT];
   logic                       over_seen   [tae_pkg::RULE_COUNT];
   logic [tae_pkg::TIME_W-1:0] over_since  [tae_pkg::RULE_COUNT];
   logic [tae_pkg::ID_W-1:0]   alarm_id    [tae_pkg::RULE_COUNT];
   logic [tae_pkg::TIME_W-1:0] alarm_at    [tae_pkg::RULE_COUNT];
   logic                       alarm_acked [tae_pkg::RULE_COUNT];
   logic [tae_pkg::ID_W-1:0]   id_next;
   logic [2:0]                 active_cnt;
   logic [1:0]                 acked_cnt;
   logic [tae_pkg::TIME_W-1:0] frame_at;
   logic                       wdog_on;

   tae_pkg::rsp_item_type  alarm_words_due[$];
   pending_word_type       send_queue[$];
   tae_pkg::req_item_type  req_now;

   // stimulus generator state
   logic [tae_pkg::TIME_W-1:0] gen_clock;
   logic [1:0]                 run_rule;
   logic                       run_up;
   int                         run_left;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          calm = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          faults = 0;
   int          words_in = 0;
   int          words_out = 0;
   int          rule_raises = 0;
   int          rule_clears = 0;
   int          wdog_raises = 0;
   int          settings_loaded = 0;

   threshold_alert_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // alarm model
   // ------------------------------------------------------------------
   function automatic tae_pkg::rsp_item_type alert_word(input logic [1:0] kind,
         input logic [tae_pkg::ID_W-1:0] id, input logic [2:0] sev,
         input logic [1:0] src, input logic [tae_pkg::TIME_W-1:0] t,
         input logic acked);
      tae_pkg::rsp_item_type w;
      w = '0;
      w.result_kind   = kind;
      w.alert_num     = id;
      w.severity      = sev;
      w.alert_source  = src;
      w.alert_time_ms = t;
      w.alert_acked   = acked;
      return w;
   endfunction

   function automatic tae_pkg::rsp_item_type counters_word();
      tae_pkg::rsp_item_type w;
      w = '0;
      w.result_kind     = tae_pkg::RES_COUNTERS;
      w.active_total    = active_cnt;
      w.acked_total     = acked_cnt;
      w.watchdog_active = wdog_on;
      w.frame_time_ms   = frame_at;
      w.last_of_run     = 1'b1;
      return w;
   endfunction

   function automatic void recount_acked();
      logic [1:0] n;
      n = '0;
      for (int i = 0; i < tae_pkg::RULE_COUNT; i++)
         if (alarm_on[i] && alarm_acked[i] && n < 2'd3)
            n++;
      acked_cnt = n;
   endfunction

   // advances the alarm state by one accepted word, queues its results
   task automatic apply_alarm_rules(input tae_pkg::req_item_type w);
      logic [1:0]                 r;
      longint                     on_level, off_level, value;
      logic [tae_pkg::TIME_W-1:0] held;
      logic                       timed_out, matched;
      r = w.rule_index;
      case (w.kind)
         tae_pkg::KIND_SAMPLE: begin
            frame_at = w.time_ms;
            if (r < tae_pkg::RULE_COUNT) begin
               on_level  = longint'(lim_set[r]);
               off_level = on_level - longint'(band_set[r]);
               value     = longint'($signed(w.sample_value));
               if (value >= on_level) begin
                  if (!over_seen[r]) begin
                     over_seen[r]  = 1'b1;
                     over_since[r] = w.time_ms;
                  end
                  held = w.time_ms - over_since[r];
                  if (!alarm_on[r] && held >= {32'd0, dur_set}) begin
                     alarm_on[r] = 1'b1;
                     if (active_cnt < 3'd7) active_cnt++;
                     alarm_id[r]    = id_next;
                     id_next        = id_next + 32'd1;
                     alarm_at[r]    = w.time_ms;
                     alarm_acked[r] = 1'b0;
                     recount_acked();
                     alarm_words_due.push_back(alert_word(tae_pkg::RES_RAISED,
                        alarm_id[r], SEV_RULE[r], r, w.time_ms, 1'b0));
                     rule_raises++;
                  end
               end else if (value <= off_level) begin
                  over_seen[r] = 1'b0;
                  if (alarm_on[r]) begin
                     alarm_on[r] = 1'b0;
                     if (active_cnt > 3'd0) active_cnt--;
                     recount_acked();
                     // clear repeats the raise time of the alarm
                     alarm_words_due.push_back(alert_word(tae_pkg::RES_CLEARED,
                        alarm_id[r], SEV_RULE[r], r, alarm_at[r], alarm_acked[r]));
                     rule_clears++;
                  end
               end
            end
            alarm_words_due.push_back(counters_word());
         end
         tae_pkg::KIND_FRAME: begin
            frame_at = w.time_ms;
            alarm_words_due.push_back(counters_word());
         end
         tae_pkg::KIND_ACK: begin
            matched = 1'b0;
            for (int i = 0; i < tae_pkg::RULE_COUNT; i++)
               if (!matched && alarm_on[i] && alarm_id[i] == w.ack_id) begin
                  alarm_acked[i] = 1'b1;
                  matched = 1'b1;
               end
            if (matched) begin
               recount_acked();
               alarm_words_due.push_back(counters_word());
            end
         end
         default: begin
            // watchdog: a zero frame time keeps it off
            held      = w.time_ms - frame_at;
            timed_out = (frame_at != '0) && (held > {16'd0, wdog_set});
            if (timed_out && !wdog_on) begin
               wdog_on = 1'b1;
               if (active_cnt < 3'd7) active_cnt++;
               alarm_words_due.push_back(alert_word(tae_pkg::RES_RAISED, id_next,
                  tae_pkg::SEV_WDOG_RAISE, tae_pkg::SRC_WATCHDOG, w.time_ms, 1'b0));
               id_next = id_next + 32'd1;
               recount_acked();
               alarm_words_due.push_back(counters_word());
               wdog_raises++;
            end else if (!timed_out && wdog_on) begin
               wdog_on = 1'b0;
               if (active_cnt > 3'd0) active_cnt--;
               alarm_words_due.push_back(alert_word(tae_pkg::RES_CLEARED, '0,
                  tae_pkg::SEV_WDOG_CLEAR, tae_pkg::SRC_WATCHDOG, w.time_ms, 1'b0));
               alarm_words_due.push_back(counters_word());
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // input driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pending_word_type nxt;
      logic             take;
      take = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_alarm_rules(req_now);
            words_in++;
            if (!calm && $urandom_range(0, 99) < send_idle_pct)
               send_gap = $urandom_range(1, 12);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0)
               send_gap--;
            else if (send_queue.size() > 0 &&
                     (!send_queue[0].hold || alarm_words_due.size() == 0))
               take = 1'b1;
            if (take) begin
               nxt     = send_queue.pop_front();
               req_now = nxt.word;
               req_tdata <= {6'd0, nxt.word.ack_id, nxt.word.time_ms,
                             nxt.word.sample_value, nxt.word.rule_index};
               req_tuser <= nxt.word.kind;
            end
            req_tvalid <= take;
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         faults++;
      end
   endtask

   always @(posedge clock) begin
      tae_pkg::rsp_item_type got;
      tae_pkg::rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.result_kind     = rsp_tuser;
            got.alert_num       = rsp_tdata[31:0];
            got.severity        = rsp_tdata[34:32];
            got.alert_source    = rsp_tdata[36:35];
            got.alert_time_ms   = rsp_tdata[84:37];
            got.alert_acked     = rsp_tdata[85];
            got.active_total    = rsp_tdata[88:86];
            got.acked_total     = rsp_tdata[90:89];
            got.watchdog_active = rsp_tdata[91];
            got.frame_time_ms   = rsp_tdata[139:92];
            got.last_of_run     = rsp_tlast;
            words_out++;
            if (alarm_words_due.size() == 0) begin
               $error("result word with nothing expected: kind %0d, id %0h",
                      got.result_kind, got.alert_num);
               faults++;
            end else begin
               want = alarm_words_due.pop_front();
               check_field("result_kind", want.result_kind, got.result_kind);
               check_field("alert_num", want.alert_num, got.alert_num);
               check_field("severity", want.severity, got.severity);
               check_field("alert_source", want.alert_source, got.alert_source);
               check_field("alert_time_ms", want.alert_time_ms, got.alert_time_ms);
               check_field("alert_acked", want.alert_acked, got.alert_acked);
               check_field("active_total", want.active_total, got.active_total);
               check_field("acked_total", want.acked_total, got.acked_total);
               check_field("watchdog_active", want.watchdog_active, got.watchdog_active);
               check_field("frame_time_ms", want.frame_time_ms, got.frame_time_ms);
               check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
         end
         // receiver stall bursts
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // register writes
   // ------------------------------------------------------------------
   task automatic write_reg(input logic [tae_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tae_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tae_pkg::REG_CELL_VOLTAGE_LIMIT: lim_set[0]  = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_PACK_DELTA_LIMIT:   lim_set[1]  = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_TEMPERATURE_LIMIT:  lim_set[2]  = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_CELL_VOLTAGE_BAND:  band_set[0] = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_PACK_DELTA_BAND:    band_set[1] = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_TEMPERATURE_BAND:   band_set[2] = data[tae_pkg::LEVEL_W-1:0];
         tae_pkg::REG_QUAL_TIME_MS:       dur_set     = data[tae_pkg::DUR_W-1:0];
         default:                         wdog_set    = data;
      endcase
   endtask

   task automatic load_settings(input logic [tae_pkg::LEVEL_W-1:0] l0, l1, l2,
                                b0, b1, b2,
                                input logic [tae_pkg::DUR_W-1:0] dur,
                                input logic [tae_pkg::TIMEOUT_W-1:0] tmo);
      write_reg(tae_pkg::REG_CELL_VOLTAGE_LIMIT, l0);
      write_reg(tae_pkg::REG_PACK_DELTA_LIMIT, l1);
      write_reg(tae_pkg::REG_TEMPERATURE_LIMIT, l2);
      write_reg(tae_pkg::REG_CELL_VOLTAGE_BAND, b0);
      write_reg(tae_pkg::REG_PACK_DELTA_BAND, b1);
      write_reg(tae_pkg::REG_TEMPERATURE_BAND, b2);
      write_reg(tae_pkg::REG_QUAL_TIME_MS, dur);
      write_reg(tae_pkg::REG_FRAME_TIMEOUT_MS, tmo);
      settings_loaded++;
   endtask

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   function automatic logic [tae_pkg::TIME_W-1:0] rand48();
      return {16'($urandom), $urandom};
   endfunction

   // mostly small forward steps, now and then a jump anywhere
   function automatic logic [tae_pkg::TIME_W-1:0] advance_clock();
      if ($urandom_range(0, 39) == 0)
         gen_clock = rand48();
      else
         gen_clock = gen_clock + 48'($urandom_range(0, int'(dur_set) / 3 + 2));
      return gen_clock;
   endfunction

   // samples come in runs on one rule that climb over or fall under the levels
   function automatic tae_pkg::req_item_type next_stimulus();
      tae_pkg::req_item_type w;
      int unsigned           roll;
      int                    base;
      longint                on_level, off_level, value;
      w              = '0;
      w.kind         = tae_pkg::KIND_SAMPLE;
      w.rule_index   = 2'($urandom_range(0, 3));
      w.sample_value = 24'($urandom);
      w.ack_id       = $urandom;
      w.time_ms      = rand48();
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         if (run_left == 0) begin
            run_rule = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            run_up   = ($urandom_range(0, 9) < 6);
            run_left = $urandom_range(2, 8);
         end
         run_left--;
         base      = (run_rule == 2'd3) ? 0 : int'(run_rule);
         on_level  = longint'(lim_set[base]);
         off_level = on_level - longint'(band_set[base]);
         roll = $urandom_range(0, 14);
         if (roll == 0)
            value = longint'($signed(24'($urandom)));
         else if (roll == 1)
            value = (on_level - off_level >= 2) ? on_level - 1 : on_level;
         else if (run_up)
            value = (roll < 4) ? on_level : on_level + $urandom_range(0, 2);
         else
            value = (roll < 4) ? off_level : off_level - $urandom_range(0, 2);
         if (value > 64'sd8388607) value = 64'sd8388607;
         if (value < -64'sd8388608) value = -64'sd8388608;
         w.rule_index   = run_rule;
         w.sample_value = value[tae_pkg::VALUE_W-1:0];
         w.time_ms      = advance_clock();
      end else if (roll < 63) begin
         w.kind    = tae_pkg::KIND_FRAME;
         w.time_ms = ($urandom_range(0, 11) == 0) ? '0 : advance_clock();
      end else if (roll < 78) begin
         w.kind = tae_pkg::KIND_ACK;
         roll   = $urandom_range(0, 99);
         if (roll < 50)
            w.ack_id = alarm_id[$urandom_range(0, tae_pkg::RULE_COUNT - 1)];
         else if (roll < 65) w.ack_id = id_next - 32'd1;
         else if (roll < 75) w.ack_id = id_next;
      end else begin
         // ticks land around the timeout edge, well inside it, or anywhere
         w.kind = tae_pkg::KIND_TICK;
         roll   = $urandom_range(0, 99);
         if (roll < 45)
            w.time_ms = gen_clock + {16'd0, wdog_set} - 48'd1 + 48'($urandom_range(0, 2));
         else if (roll < 80)
            w.time_ms = gen_clock + 48'($urandom_range(0, wdog_set));
      end
      return w;
   endfunction

   task automatic run_random(input int count);
      pending_word_type e;
      gen_clock = 48'($urandom_range(1, 100000));
      run_left  = 0;
      for (int n = 0; n < count; n++) begin
         do @(negedge clock); while (send_queue.size() >= 4);
         e.word = next_stimulus();
         e.hold = (n % 97 == 50);
         send_queue.push_back(e);
      end
   endtask

   task automatic queue_word(input logic [1:0] kind, input logic [1:0] rule,
                             input logic [tae_pkg::VALUE_W-1:0] value,
                             input logic [tae_pkg::TIME_W-1:0] t,
                             input logic [tae_pkg::ID_W-1:0] ack);
      pending_word_type e;
      e.word.kind         = kind;
      e.word.rule_index   = rule;
      e.word.sample_value = value;
      e.word.time_ms      = t;
      e.word.ack_id       = ack;
      e.hold              = 1'b0;
      send_queue.push_back(e);
   endtask

   // wait until the engine is idle, including words that cause no result
   task automatic settle();
      do @(negedge clock);
      while (send_queue.size() != 0 || req_tvalid || alarm_words_due.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      lim_set[0]  = tae_pkg::RST_CELL_VOLTAGE_LIMIT;
      lim_set[1]  = tae_pkg::RST_PACK_DELTA_LIMIT;
      lim_set[2]  = tae_pkg::RST_TEMPERATURE_LIMIT;
      band_set[0] = tae_pkg::RST_CELL_VOLTAGE_BAND;
      band_set[1] = tae_pkg::RST_PACK_DELTA_BAND;
      band_set[2] = tae_pkg::RST_TEMPERATURE_BAND;
      dur_set     = tae_pkg::RST_QUAL_TIME_MS;
      wdog_set    = tae_pkg::RST_FRAME_TIMEOUT_MS;
      for (int i = 0; i < tae_pkg::RULE_COUNT; i++) begin
         alarm_on[i]    = 1'b0;
         over_seen[i]   = 1'b0;
         over_since[i]  = '0;
         alarm_id[i]    = '0;
         alarm_at[i]    = '0;
         alarm_acked[i] = 1'b0;
      end
      id_next    = 32'd1;
      active_cnt = '0;
      acked_cnt  = '0;
      frame_at   = '0;
      wdog_on    = 1'b0;
      gen_clock  = '0;
      run_rule   = '0;
      run_up     = 1'b0;
      run_left   = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed words under reset settings
      send_idle_pct = 20;
      recv_idle_pct = 20;
      @(negedge clock);
      // watchdog off at start
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd100000, 32'd0);
      // at limit, qualify
      queue_word(tae_pkg::KIND_SAMPLE, 2'd0, 24'd58400,  48'd1000,   32'd0);
      // one ms short
      queue_word(tae_pkg::KIND_SAMPLE, 2'd0, 24'd58400,  48'd1499,   32'd0);
      // raises
      queue_word(tae_pkg::KIND_SAMPLE, 2'd0, 24'd60000,  48'd1500,   32'd0);
      queue_word(tae_pkg::KIND_ACK,    2'd0, 24'd0,      48'd0,      32'd1);
      // no match
      queue_word(tae_pkg::KIND_ACK,    2'd0, 24'd0,      48'd0,      32'd99);
      // inside band
      queue_word(tae_pkg::KIND_SAMPLE, 2'd0, 24'd57601,  48'd1600,   32'd0);
      // clears, acked
      queue_word(tae_pkg::KIND_SAMPLE, 2'd0, 24'd57600,  48'd1700,   32'd0);
      // rule out of range
      queue_word(tae_pkg::KIND_SAMPLE, 2'd3, 24'h7FFFFF, 48'd1800,   32'd0);
      queue_word(tae_pkg::KIND_SAMPLE, 2'd1, 24'h7FFFFF, 48'd2000,   32'd0);
      queue_word(tae_pkg::KIND_SAMPLE, 2'd1, 24'h7FFFFF, 48'd2600,   32'd0);
      // most negative
      queue_word(tae_pkg::KIND_SAMPLE, 2'd2, 24'h800000, 48'd2700,   32'd0);
      queue_word(tae_pkg::KIND_FRAME,  2'd0, 24'd0,      48'd3000,   32'd0);
      // exactly timeout
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd8000,   32'd0);
      // watchdog raise
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd8001,   32'd0);
      // watchdog not ackable
      queue_word(tae_pkg::KIND_ACK,    2'd0, 24'd0,      48'd0,      32'd3);
      // watchdog clear
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd3000,   32'd0);
      // disables watchdog
      queue_word(tae_pkg::KIND_FRAME,  2'd0, 24'd0,      48'd0,      32'd0);
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'hFFFF_FFFF_FFFF, 32'd0);
      queue_word(tae_pkg::KIND_FRAME,  2'd0, 24'd0,      48'hFFFF_FFFF_FF9C, 32'd0);
      // wraps past 2^48
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd10000,  32'd0);
      queue_word(tae_pkg::KIND_SAMPLE, 2'd2, 24'd960,    48'd5000,   32'd0);
      // time backwards
      queue_word(tae_pkg::KIND_SAMPLE, 2'd2, 24'd960,    48'd4000,   32'd0);
      queue_word(tae_pkg::KIND_TICK,   2'd0, 24'd0,      48'd4000,   32'd0);
      queue_word(tae_pkg::KIND_SAMPLE, 2'd1, 24'd0,      48'd6000,   32'd0);
      queue_word(tae_pkg::KIND_ACK,    2'd0, 24'd0,      48'd0,      32'hFFFF_FFFF);
      settle();

      // zero limits with full bands: clear level far below zero
      send_idle_pct = 30;
      recv_idle_pct = 30;
      load_settings('0, '0, '0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, '0, '0);
      run_random(PHASE_WORDS);
      settle();

      // top limits, no band, longest qualification and timeout; no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_settings(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, '0, '0, '0, 16'hFFFF, 32'hFFFF_FFFF);
      run_random(PHASE_WORDS);
      settle();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 0) ? 50 : (p == 1) ? 10 : (p == 2) ? 25 : 40;
         recv_idle_pct = (p == 0) ? 10 : (p == 1) ? 50 : (p == 2) ? 25 : 40;
         load_settings($urandom_range(0, LEVEL_MAX), $urandom_range(0, 8000),
                       $urandom_range(0, 4000),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, LEVEL_MAX)
                                                   : $urandom_range(0, 4000),
                       $urandom_range(0, 1000), $urandom_range(0, 200),
                       $urandom_range(0, 1000),
                       ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20000));
         run_random(PHASE_WORDS);
         settle();
      end

      // back to the reset settings, full rate on both sides
      calm = 1'b1;
      load_settings(tae_pkg::RST_CELL_VOLTAGE_LIMIT, tae_pkg::RST_PACK_DELTA_LIMIT,
                    tae_pkg::RST_TEMPERATURE_LIMIT, tae_pkg::RST_CELL_VOLTAGE_BAND,
                    tae_pkg::RST_PACK_DELTA_BAND, tae_pkg::RST_TEMPERATURE_BAND,
                    tae_pkg::RST_QUAL_TIME_MS, tae_pkg::RST_FRAME_TIMEOUT_MS);
      run_random(PHASE_WORDS);

      // drain
      do @(negedge clock); while (send_queue.size() != 0 || req_tvalid);
      for (int n = 0; n < 4000 && alarm_words_due.size() != 0; n++)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (alarm_words_due.size() != 0) begin
         $error("%0d expected result words never arrived", alarm_words_due.size());
         faults++;
      end

      $display("covered %0d input words and %0d result words over %0d register settings",
               words_in, words_out, settings_loaded);
      $display("rule alarms raised %0d, cleared %0d; watchdog alarms raised %0d",
               rule_raises, rule_clears, wdog_raises);
      if (faults == 0)
         $display("threshold_alert_engine regression: pass");
      else
         $display("threshold_alert_engine regression: fail");
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("threshold_alert_engine regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
src/tae_pkg.sv
src/tae_csr_regs.sv
src/tae_alarm_core.sv
src/tae_result_buffer.sv
src/threshold_alert_engine.sv
src/tae_checker.sv
tb/sv/threshold_alert_engine_tb.sv
